FILE: rtl/rgbq_pkg.sv
// Shared types and constants for the ratio graph query core.
// No dependencies; imported by every other RTL file.
`default_nettype none
package rgbq_pkg;

    localparam int ID_W = 6;
    localparam int Q_W  = 32;

    localparam logic [Q_W-1:0] Q_ONE   = 32'h0001_0000;
    localparam logic [Q_W-1:0] Q_MAX   = 32'h7FFF_FFFF;
    localparam logic [Q_W-1:0] Q_MIN   = 32'h8000_0000;
    localparam logic [Q_W-1:0] MIN_MAG = 32'd7;

    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_ADD   = 2'd1;
    localparam logic [1:0] OP_QUERY = 2'd2;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_NO_ANS = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;

    typedef struct packed {
        logic start;
        logic recip;
    } arith_req_t;

endpackage
`default_nettype wire

FILE: rtl/rgbq_arith.sv
// Shared arithmetic unit: Q16.16 saturating multiply and
// rounded reciprocal by restoring division (one quotient bit a cycle).
// Depends on rgbq_pkg.
`default_nettype none
module rgbq_arith
    import rgbq_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire arith_req_t       req,
    input  wire logic [Q_W-1:0]   opa,
    input  wire logic [Q_W-1:0]   opb,
    output logic                  done,
    output logic [Q_W-1:0]       result
);

    logic               busy_reg, busy_next;
    logic               recip_reg, recip_next;
    logic [5:0]         cnt_reg, cnt_next;
    logic               done_reg, done_next;
    logic signed [63:0] prod_reg;
    logic [Q_W-1:0]     res_reg;
    logic [Q_W-1:0]     mag_reg;
    logic [Q_W:0]       num_reg;
    logic [Q_W-1:0]     rem_reg;
    logic [Q_W:0]       quo_reg;
    logic               neg_reg;

    logic [63:0] pmag;
    logic [47:0] pround;
    logic [Q_W-1:0] mul_res;
    logic [Q_W:0]   rem_sh;
    logic           take;
    logic [Q_W:0]   quo_sh;
    logic [Q_W-1:0] amag;

    always_comb begin
        pmag   = prod_reg[63] ? (64'd0 - 64'(prod_reg)) : 64'(prod_reg);
        pround = 48'((pmag + 64'h8000) >> 16);
        if (prod_reg[63]) begin
            if (pround >= 48'h8000_0000) mul_res = Q_MIN;
            else mul_res = Q_W'(32'd0 - pround[Q_W-1:0]);
        end else begin
            if (pround > 48'h7FFF_FFFF) mul_res = Q_MAX;
            else mul_res = pround[Q_W-1:0];
        end
        rem_sh = {rem_reg, num_reg[Q_W]};
        take   = rem_sh >= {1'b0, mag_reg};
        quo_sh = {quo_reg[Q_W-1:0], take};
        amag   = opa[Q_W-1] ? (32'd0 - opa) : opa;
    end

    always_comb begin
        busy_next  = busy_reg;
        recip_next = recip_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        if (req.start) begin
            busy_next  = 1'b1;
            recip_next = req.recip;
            cnt_next   = 6'(Q_W + 1);
        end else if (busy_reg) begin
            if (!recip_reg) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                cnt_next = cnt_reg - 6'd1;
                if (cnt_reg == 6'd1) begin
                    busy_next = 1'b0;
                    done_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            recip_reg <= 1'b0;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end else begin
            busy_reg  <= busy_next;
            recip_reg <= recip_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            prod_reg <= $signed(opa) * $signed(opb);
            mag_reg  <= amag;
            neg_reg  <= opa[Q_W-1];
            num_reg  <= {1'b1, 32'd0} + {2'b0, amag[Q_W-1:1]};
            rem_reg  <= '0;
            quo_reg  <= '0;
        end else if (busy_reg) begin
            if (!recip_reg) begin
                res_reg <= mul_res;
            end else begin
                rem_reg <= take ? Q_W'(rem_sh - {1'b0, mag_reg}) : rem_sh[Q_W-1:0];
                num_reg <= {num_reg[Q_W-1:0], 1'b0};
                quo_reg <= quo_sh;
                if (cnt_reg == 6'd1) begin
                    res_reg <= neg_reg ? (32'd0 - quo_sh[Q_W-1:0]) : quo_sh[Q_W-1:0];
                end
            end
        end
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule
`default_nettype wire

FILE: rtl/ratio_graph_bfs_query_core.sv
// Ratio equation store with breadth-first query; top level.
// Depends on rgbq_pkg and rgbq_arith.
`default_nettype none
// Each request gives one result. An add that also stores the reverse edge
// needs a reciprocal, which the shared unit divides out one bit a cycle.
// A query runs a breadth-first search: for each dequeued node other than
// the destination it walks every stored edge, and each newly discovered
// node costs one multiply in the shared unit. The block takes no new
// request until the current one has its result in the output register.
module ratio_graph_bfs_query_core
    import rgbq_pkg::*;
#(
    parameter int MAX_NODES = 64,
    parameter int MAX_EDGES = 128
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_valid,
    output logic                 s_ready,
    input  wire logic [1:0]      s_operation,
    input  wire logic [ID_W-1:0] s_first_node,
    input  wire logic [ID_W-1:0] s_second_node,
    input  wire logic [Q_W-1:0]  s_ratio,
    output logic                 m_valid,
    input  wire logic            m_ready,
    output logic [Q_W-1:0]       m_quotient,
    output logic [1:0]           m_status
);

    localparam int NODES = (MAX_NODES < (1 << ID_W)) ? MAX_NODES : (1 << ID_W);
    localparam int NI_W  = $clog2(NODES);
    localparam int QC_W  = $clog2(NODES + 1);
    localparam int EA_W  = $clog2(MAX_EDGES);
    localparam int EC_W  = $clog2(MAX_EDGES + 1);

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_DIV       = 4'd1;
    localparam logic [3:0] S_POP       = 4'd2;
    localparam logic [3:0] S_POP_WAIT  = 4'd3;
    localparam logic [3:0] S_NODE_WAIT = 4'd4;
    localparam logic [3:0] S_SCAN      = 4'd5;
    localparam logic [3:0] S_EDGE      = 4'd6;
    localparam logic [3:0] S_MUL       = 4'd7;
    localparam logic [3:0] S_FIN       = 4'd8;
    localparam logic [3:0] S_FIN_WAIT  = 4'd9;
    localparam logic [3:0] S_FIN_READ  = 4'd10;
    localparam logic [3:0] S_RESP      = 4'd11;

    logic [3:0]      state_reg, state_next;
    logic [EC_W-1:0] ecount_reg, ecount_next;
    logic [NODES-1:0] known_reg, known_next;
    logic [NODES-1:0] visited_reg, visited_next;
    logic [QC_W-1:0] head_reg, head_next;
    logic [QC_W-1:0] tail_reg, tail_next;
    logic [EC_W-1:0] k_reg, k_next;
    logic [NI_W-1:0] na_reg, na_next;
    logic [NI_W-1:0] nb_reg, nb_next;
    logic [NI_W-1:0] node_reg, node_next;
    logic [NI_W-1:0] tgt_reg, tgt_next;
    logic [NI_W-1:0] pp_raddr_reg, pp_raddr_next;
    logic [Q_W-1:0]  rquot_reg, rquot_next;
    logic [1:0]      rstat_reg, rstat_next;
    logic            m_valid_reg, m_valid_next;
    logic [Q_W-1:0]  m_quot_reg;
    logic [1:0]      m_stat_reg;

    // Edge store, node path products and search queue.
    logic [NI_W-1:0] esrc_mem [MAX_EDGES];
    logic [NI_W-1:0] etgt_mem [MAX_EDGES];
    logic [Q_W-1:0]  ew_mem   [MAX_EDGES];
    logic [Q_W-1:0]  pp_mem   [NODES];
    logic [NI_W-1:0] q_mem    [NODES];
    logic [NI_W-1:0] esrc_q, etgt_q, q_q;
    logic [Q_W-1:0]  ew_q, pp_q;

    logic            e_we;
    logic [NI_W-1:0] e_wsrc, e_wtgt;
    logic [Q_W-1:0]  e_ww;
    logic            pp_we;
    logic [NI_W-1:0] pp_waddr;
    logic [Q_W-1:0]  pp_wdata;
    logic            q_we;
    logic [QC_W-1:0] q_waddr;
    logic [NI_W-1:0] q_wdata;

    arith_req_t      areq;
    logic [Q_W-1:0]  aopa, aopb, ares;
    logic            adone;

    logic accept, ids_ok, both, full;
    logic [NI_W-1:0] ia, ib;

    rgbq_arith u_arith (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (areq),
        .opa     (aopa),
        .opb     (aopb),
        .done    (adone),
        .result  (ares)
    );

    assign s_ready = (state_reg == S_IDLE);
    assign accept  = s_valid && s_ready;
    assign ia      = s_first_node[NI_W-1:0];
    assign ib      = s_second_node[NI_W-1:0];

    always_comb begin
        ids_ok = (32'(s_first_node) < MAX_NODES) && (32'(s_second_node) < MAX_NODES);
        both   = (s_ratio[Q_W-1] ? (32'd0 - s_ratio) : s_ratio) >= MIN_MAG;
        full   = (32'(ecount_reg) + (both ? 32'd2 : 32'd1)) > MAX_EDGES;
    end

    always_comb begin
        state_next    = state_reg;
        ecount_next   = ecount_reg;
        known_next    = known_reg;
        visited_next  = visited_reg;
        head_next     = head_reg;
        tail_next     = tail_reg;
        k_next        = k_reg;
        na_next       = na_reg;
        nb_next       = nb_reg;
        node_next     = node_reg;
        tgt_next      = tgt_reg;
        pp_raddr_next = pp_raddr_reg;
        rquot_next    = rquot_reg;
        rstat_next    = rstat_reg;
        m_valid_next  = m_valid_reg;
        e_we = 1'b0; e_wsrc = ia; e_wtgt = ib; e_ww = s_ratio;
        pp_we = 1'b0; pp_waddr = tgt_reg; pp_wdata = ares;
        q_we = 1'b0; q_waddr = tail_reg; q_wdata = tgt_reg;
        areq = '0; aopa = s_ratio; aopb = ew_q;

        if (m_valid_reg && m_ready) m_valid_next = 1'b0;

        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    na_next    = ia;
                    nb_next    = ib;
                    rquot_next = '0;
                    rstat_next = ST_OK;
                    state_next = S_RESP;
                    case (s_operation)
                        OP_CLEAR: begin
                            ecount_next = '0;
                            known_next  = '0;
                        end
                        OP_ADD: begin
                            if (!ids_ok) begin
                                rstat_next = ST_NO_ANS;
                            end else if (full) begin
                                rstat_next = ST_FULL;
                            end else begin
                                e_we         = 1'b1;
                                ecount_next  = ecount_reg + EC_W'(1);
                                known_next[ia] = 1'b1;
                                known_next[ib] = 1'b1;
                                if (both) begin
                                    areq.start = 1'b1;
                                    areq.recip = 1'b1;
                                    state_next = S_DIV;
                                end
                            end
                        end
                        OP_QUERY: begin
                            if (!ids_ok || !known_reg[ia] || !known_reg[ib]) begin
                                rstat_next = ST_NO_ANS;
                            end else if (ia == ib) begin
                                rquot_next = Q_ONE;
                            end else begin
                                visited_next     = '0;
                                visited_next[ia] = 1'b1;
                                pp_we     = 1'b1;
                                pp_waddr  = ia;
                                pp_wdata  = Q_ONE;
                                q_we      = 1'b1;
                                q_waddr   = '0;
                                q_wdata   = ia;
                                head_next = '0;
                                tail_next = QC_W'(1);
                                state_next = S_POP;
                            end
                        end
                        default: rstat_next = ST_NO_ANS;
                    endcase
                end
            end
            S_DIV: begin
                if (adone) begin
                    e_we        = 1'b1;
                    e_wsrc      = nb_reg;
                    e_wtgt      = na_reg;
                    e_ww        = ares;
                    ecount_next = ecount_reg + EC_W'(1);
                    state_next  = S_RESP;
                end
            end
            S_POP: begin
                state_next = (head_reg < tail_reg) ? S_POP_WAIT : S_FIN;
            end
            S_POP_WAIT: begin
                head_next = head_reg + QC_W'(1);
                node_next = q_q;
                if (q_q == nb_reg) begin
                    state_next = S_FIN;
                end else begin
                    pp_raddr_next = q_q;
                    k_next        = '0;
                    state_next    = S_NODE_WAIT;
                end
            end
            S_NODE_WAIT: state_next = S_SCAN;
            S_SCAN: begin
                state_next = (k_reg < ecount_reg) ? S_EDGE : S_POP;
            end
            S_EDGE: begin
                if (esrc_q == node_reg && !visited_reg[etgt_q]) begin
                    areq.start = 1'b1;
                    aopa       = pp_q;
                    tgt_next   = etgt_q;
                    state_next = S_MUL;
                end else begin
                    k_next     = k_reg + EC_W'(1);
                    state_next = S_SCAN;
                end
            end
            S_MUL: begin
                aopa = pp_q;
                if (adone) begin
                    pp_we = 1'b1;
                    visited_next[tgt_reg] = 1'b1;
                    if (32'(tail_reg) < NODES) begin
                        q_we      = 1'b1;
                        tail_next = tail_reg + QC_W'(1);
                    end
                    k_next     = k_reg + EC_W'(1);
                    state_next = S_SCAN;
                end
            end
            S_FIN: begin
                if (visited_reg[nb_reg]) begin
                    pp_raddr_next = nb_reg;
                    state_next    = S_FIN_WAIT;
                end else begin
                    rstat_next = ST_NO_ANS;
                    state_next = S_RESP;
                end
            end
            S_FIN_WAIT: state_next = S_FIN_READ;
            S_FIN_READ: begin
                rquot_next = pp_q;
                state_next = S_RESP;
            end
            S_RESP: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            ecount_reg  <= '0;
            known_reg   <= '0;
            visited_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            ecount_reg  <= ecount_next;
            known_reg   <= known_next;
            visited_reg <= visited_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        head_reg     <= head_next;
        tail_reg     <= tail_next;
        k_reg        <= k_next;
        na_reg       <= na_next;
        nb_reg       <= nb_next;
        node_reg     <= node_next;
        tgt_reg      <= tgt_next;
        pp_raddr_reg <= pp_raddr_next;
        rquot_reg    <= rquot_next;
        rstat_reg    <= rstat_next;
        if (state_reg == S_RESP && (!m_valid_reg || m_ready)) begin
            m_quot_reg <= rquot_reg;
            m_stat_reg <= rstat_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (e_we) begin
            esrc_mem[ecount_reg[EA_W-1:0]] <= e_wsrc;
            etgt_mem[ecount_reg[EA_W-1:0]] <= e_wtgt;
            ew_mem[ecount_reg[EA_W-1:0]]   <= e_ww;
        end
        esrc_q <= esrc_mem[k_reg[EA_W-1:0]];
        etgt_q <= etgt_mem[k_reg[EA_W-1:0]];
        ew_q   <= ew_mem[k_reg[EA_W-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (pp_we) pp_mem[pp_waddr] <= pp_wdata;
        pp_q <= pp_mem[pp_raddr_reg];
    end

    always_ff @(posedge aclk) begin
        if (q_we) q_mem[q_waddr[NI_W-1:0]] <= q_wdata;
        q_q <= q_mem[head_reg[NI_W-1:0]];
    end

    assign m_valid    = m_valid_reg;
    assign m_quotient = m_quot_reg;
    assign m_status   = m_stat_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(ecount_reg) <= MAX_EDGES)
        else $error("edge count beyond store size");

    a_done_expected: assert property (@(posedge aclk) disable iff (!aresetn)
        adone |-> (state_reg == S_DIV || state_reg == S_MUL))
        else $error("arithmetic result with no operation pending");

    a_queue_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_POP || state_reg == S_SCAN) |-> (head_reg <= tail_reg))
        else $error("search queue head passed tail");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_RESP && m_valid_reg && !m_ready) |=> m_valid_reg)
        else $error("pending result dropped");

endmodule
`default_nettype wire
